@@ hw/rtl/bdlp_pkg.sv @@
// ----------------------------------------------------------------------------
// Button debounce package
// Shared types and constants for the debouncer with long-press detection.
// ----------------------------------------------------------------------------
`default_nettype none

package bdlp_pkg;

  localparam int NUM_BUTTONS = 3;
  localparam int TIME_W      = 32;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int BTN_IDX_W   = 2;

  localparam logic [CFG_W-1:0] DEBOUNCE_RESET   = 16'd30;
  localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd1200;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd1;

  typedef struct packed {
    logic [TIME_W-1:0]      now_ms;
    logic [NUM_BUTTONS-1:0] raw_levels;
  } in_item_t;

  typedef struct packed {
    logic                 event_valid;
    logic [BTN_IDX_W-1:0] event_button;
    logic                 event_long;
  } out_item_t;

  // Per-button debounce state.
  typedef struct packed {
    logic              sampled;
    logic              stable;
    logic [TIME_W-1:0] change_time;
    logic [TIME_W-1:0] press_time;
    logic              long_done;
  } btn_state_t;

  // Event raised by one button in one poll.
  typedef struct packed {
    logic hit;
    logic is_long;
  } btn_evt_t;

endpackage

`default_nettype wire

@@ hw/rtl/bdlp_button.sv @@
// ----------------------------------------------------------------------------
// Button debounce cell
// Evaluates one button for one poll and produces its next state and event.
// ----------------------------------------------------------------------------
`default_nettype none

module bdlp_button (
  input  wire logic                        en,
  input  wire logic [bdlp_pkg::TIME_W-1:0] now_ms,
  input  wire logic                        level,
  input  wire logic [bdlp_pkg::CFG_W-1:0]  debounce_time,
  input  wire logic [bdlp_pkg::CFG_W-1:0]  long_press_time,
  input  wire bdlp_pkg::btn_state_t        st,
  output bdlp_pkg::btn_state_t             st_next,
  output bdlp_pkg::btn_evt_t               evt
);
  import bdlp_pkg::*;

  logic              changed;
  logic [TIME_W-1:0] ct;
  logic [TIME_W-1:0] since_change;
  logic [TIME_W-1:0] since_press;
  logic              hold;

  always_comb begin
    changed      = (level != st.sampled);
    ct           = changed ? now_ms : st.change_time;
    since_change = now_ms - ct;
    since_press  = now_ms - st.press_time;
    // The level is kept when it matches the stable one or has not held long enough.
    hold = (level == st.stable) ||
           (since_change < {{(TIME_W-CFG_W){1'b0}}, debounce_time});

    st_next     = st;
    evt.hit     = 1'b0;
    evt.is_long = 1'b0;

    if (en) begin
      st_next.sampled     = level;
      st_next.change_time = ct;
      if (hold) begin
        if (!level && !st.stable && !st.long_done &&
            (since_press >= {{(TIME_W-CFG_W){1'b0}}, long_press_time})) begin
          st_next.long_done = 1'b1;
          evt.hit           = 1'b1;
          evt.is_long       = 1'b1;
        end
      end else begin
        st_next.stable = level;
        if (!level) begin
          st_next.press_time = now_ms;
          st_next.long_done  = 1'b0;
        end else if (!st.long_done) begin
          evt.hit = 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/bdlp_out_reg.sv @@
// ----------------------------------------------------------------------------
// Button debounce result register
// Holds one result until the receiver takes it and paces the stage before it.
// ----------------------------------------------------------------------------
`default_nettype none

module bdlp_out_reg (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                src_valid,
  input  wire bdlp_pkg::out_item_t src_data,
  output logic                     advance,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output bdlp_pkg::out_item_t      out_data
);
  import bdlp_pkg::*;

  // The register may take a new result when empty or when its content leaves now.
  assign advance = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && src_valid) begin
      out_data <= src_data;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/button_debounce_long_press.sv @@
// ----------------------------------------------------------------------------
// Button debouncer with long-press detection
// Debounces three active-low buttons and reports short and long presses.
// ----------------------------------------------------------------------------
// Each transfer on the input channel is one poll: a millisecond timestamp and
// the raw active-low button levels. Every poll yields exactly one result on the
// output channel; event_valid tells whether the poll reported an event.
// Buttons are checked in index order and the first event ends the poll.
// A poll is taken into the input register, evaluated from there, and its result
// is captured in the result register, from which it is offered.
// Throughput: one poll per cycle while the receiver does not stall; the debounce
// state of every button is written as the poll moves on to the result register.
// When the receiver stalls, the result register holds and in_stall rises as
// soon as the input register is also occupied.
// Configuration writes (index 0 debounce time, index 1 long-press time) are
// always taken and should be issued only while the block is idle; other
// indexes are ignored.
// Reset restores both times to 30 and 1200 ms, marks all buttons released,
// clears all timestamps and long-press flags and empties both registers.
// ----------------------------------------------------------------------------
`default_nettype none

module button_debounce_long_press (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire bdlp_pkg::in_item_t               in_data,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output bdlp_pkg::out_item_t                   out_data,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [bdlp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [bdlp_pkg::CFG_W-1:0]       cfg_data
);
  import bdlp_pkg::*;

  logic [CFG_W-1:0] debounce_time;
  logic [CFG_W-1:0] long_press_time;

  logic     in_valid_r;
  in_item_t in_r;
  logic     advance;
  logic     take_poll;

  btn_state_t             st      [NUM_BUTTONS];
  btn_state_t             st_next [NUM_BUTTONS];
  btn_evt_t               evt     [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] en;
  out_item_t              result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_time   <= DEBOUNCE_RESET;
      long_press_time <= LONG_PRESS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DEBOUNCE:   debounce_time   <= cfg_data;
        REG_LONG_PRESS: long_press_time <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register: refilled whenever its poll moves on to the result register.
  assign take_poll = in_valid_r && advance;
  assign in_stall  = in_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_r <= in_data;
    end
  end

  assign en[0] = 1'b1;

  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_btn
    bdlp_button u_btn (
      .en              (en[i]),
      .now_ms          (in_r.now_ms),
      .level           (in_r.raw_levels[i]),
      .debounce_time   (debounce_time),
      .long_press_time (long_press_time),
      .st              (st[i]),
      .st_next         (st_next[i]),
      .evt             (evt[i])
    );

    // A later button is only looked at when no earlier one raised an event.
    if (i < NUM_BUTTONS - 1) begin : g_en
      assign en[i+1] = en[i] && !evt[i].hit;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st[i].sampled     <= 1'b1;
        st[i].stable      <= 1'b1;
        st[i].change_time <= '0;
        st[i].press_time  <= '0;
        st[i].long_done   <= 1'b0;
      end else if (take_poll) begin
        st[i] <= st_next[i];
      end
    end
  end

  // At most one button can hit, since each hit disables the rest.
  always_comb begin
    result = '0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (evt[i].hit) begin
        result.event_valid  = 1'b1;
        result.event_button = BTN_IDX_W'(i);
        result.event_long   = evt[i].is_long;
      end
    end
  end

  bdlp_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .src_valid (in_valid_r),
    .src_data  (result),
    .advance   (advance),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> in_valid_r)
    else $error("input stalled with an empty input register");

  a_held_item_stays: assert property (@(posedge clk) disable iff (rst)
    in_valid_r && !advance |=> in_valid_r)
    else $error("poll lost while the result register was blocked");

  a_quiet_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.event_valid |->
      out_data.event_button == '0 && !out_data.event_long)
    else $error("result without an event carries event fields");

  a_button_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.event_valid |->
      32'(out_data.event_button) < NUM_BUTTONS)
    else $error("event names a button that does not exist");

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the button debouncer with long-press detection
// Sends polls with timestamps and raw button levels, predicts each poll's
// event and compares it with the result, under random gaps and stalls.
// ----------------------------------------------------------------------------

module tb_top;
  import bdlp_pkg::*;

  // Any index other than the two real registers must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  class debounce_scoreboard;
    logic [NUM_BUTTONS-1:0] sampled_lvl;
    logic [NUM_BUTTONS-1:0] stable_lvl;
    logic [NUM_BUTTONS-1:0] long_seen;
    logic [TIME_W-1:0]      change_ms [NUM_BUTTONS];
    logic [TIME_W-1:0]      press_ms  [NUM_BUTTONS];
    logic [CFG_W-1:0]       debounce_ms;
    logic [CFG_W-1:0]       long_ms;
    out_item_t              expected_events [$];
    int                     errors;

    function new();
      sampled_lvl = '1;
      stable_lvl  = '1;
      long_seen   = '0;
      debounce_ms = DEBOUNCE_RESET;
      long_ms     = LONG_PRESS_RESET;
      errors      = 0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        change_ms[i] = '0;
        press_ms[i]  = '0;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_DEBOUNCE:   debounce_ms = val;
        REG_LONG_PRESS: long_ms     = val;
        default: ;
      endcase
    endfunction

    // Works out the event of one accepted poll and updates the button state.
    function void predict_press_event(in_item_t p);
      out_item_t         ev;
      logic              lvl;
      logic              stb;
      logic [TIME_W-1:0] since_change;
      logic [TIME_W-1:0] since_press;
      ev = '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        lvl = p.raw_levels[i];
        stb = stable_lvl[i];
        if (lvl != sampled_lvl[i]) begin
          sampled_lvl[i] = lvl;
          change_ms[i]   = p.now_ms;
        end
        since_change = p.now_ms - change_ms[i];
        since_press  = p.now_ms - press_ms[i];
        if (lvl == stb || since_change < TIME_W'(debounce_ms)) begin
          if (!lvl && !stb && !long_seen[i] && since_press >= TIME_W'(long_ms)) begin
            long_seen[i]    = 1'b1;
            ev.event_valid  = 1'b1;
            ev.event_button = BTN_IDX_W'(i);
            ev.event_long   = 1'b1;
            break;
          end
        end else begin
          stable_lvl[i] = lvl;
          if (!lvl) begin
            press_ms[i]  = p.now_ms;
            long_seen[i] = 1'b0;
          end else if (!long_seen[i]) begin
            // A release that closes a press without a long event is a short one.
            ev.event_valid  = 1'b1;
            ev.event_button = BTN_IDX_W'(i);
            ev.event_long   = 1'b0;
            break;
          end
        end
      end
      expected_events.push_back(ev);
    endfunction

    function void report(string field, int want, int got);
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      errors++;
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_events.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, got);
        errors++;
        return;
      end
      want = expected_events.pop_front();
      if (got.event_valid !== want.event_valid)
        report("event_valid", want.event_valid, got.event_valid);
      if (got.event_button !== want.event_button)
        report("event_button", want.event_button, got.event_button);
      if (got.event_long !== want.event_long)
        report("event_long", want.event_long, got.event_long);
    endfunction

    function int pending();
      return expected_events.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_stall;
  in_item_t               in_data;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_item_t              out_data;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_W-1:0]       cfg_data;

  debounce_scoreboard     sb;
  int                     burst_left = 0;
  int                     stall_pct  = 0;
  int                     stall_left = 0;
  logic [TIME_W-1:0]      cur_ms;
  logic [NUM_BUTTONS-1:0] held_levels;

  button_debounce_long_press dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver stalls with a probability of 0, 25, 50 or 75 percent, redrawn at random intervals.
  always @(negedge clk) begin
    if (rst) begin
      out_stall = 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_left = $urandom_range(20, 150);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 25;
          2: stall_pct = 50;
          default: stall_pct = 75;
        endcase
      end
      stall_left--;
      out_stall = ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Predict on every input transfer before checking the output transfer.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.predict_press_event(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  task automatic send_poll(input logic [TIME_W-1:0] now, input logic [NUM_BUTTONS-1:0] raw);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid           = 1'b1;
    in_data.now_ms     = now;
    in_data.raw_levels = raw;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    burst_left = 0;
  endtask

  task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [TIME_W-1:0] time_step(int d, int l);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom_range(0, d / 2 + 1);
      4, 5:       return $urandom_range(d / 2, d + 2);
      6, 7, 8:    return $urandom_range(0, l + d + 2);
      default:    return $urandom_range(l, l + d + 100);
    endcase
  endfunction

  // Mostly button presses with contact bounce on an advancing clock; a few
  // polls carry a random time and random levels.
  task automatic random_polls(input int d, input int l, input int count);
    logic [NUM_BUTTONS-1:0] raw;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 99) < 8) begin
        cur_ms = $urandom;
        raw    = NUM_BUTTONS'($urandom_range(0, 7));
      end else begin
        if ($urandom_range(0, 3) == 0)
          held_levels[$urandom_range(0, NUM_BUTTONS - 1)] ^= 1'b1;
        raw = held_levels;
        if ($urandom_range(0, 9) == 0)
          raw[$urandom_range(0, NUM_BUTTONS - 1)] ^= 1'b1;
        cur_ms = cur_ms + time_step(d, l);
      end
      send_poll(cur_ms, raw);
    end
  endtask

  initial begin
    int d;
    int l;
    sb          = new();
    rst         = 1'b1;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_DEBOUNCE;
    cfg_data    = '0;
    cur_ms      = '0;
    held_levels = '1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset timing: press, long press, release after long, short press,
    // priority among three releases, and a debounce across the time wrap.
    send_poll(32'd0,    3'b111);
    send_poll(32'd10,   3'b110);
    send_poll(32'd39,   3'b110);
    send_poll(32'd40,   3'b110);
    send_poll(32'd1239, 3'b110);
    send_poll(32'd1240, 3'b110);
    send_poll(32'd1300, 3'b111);
    send_poll(32'd1330, 3'b111);
    send_poll(32'd1400, 3'b101);
    send_poll(32'd1430, 3'b101);
    send_poll(32'd1500, 3'b111);
    send_poll(32'd1530, 3'b111);
    send_poll(32'd1600, 3'b000);
    send_poll(32'd1630, 3'b000);
    send_poll(32'd1700, 3'b111);
    send_poll(32'd1730, 3'b111);
    send_poll(32'd1731, 3'b111);
    send_poll(32'd1732, 3'b111);
    send_poll(32'hFFFF_FFF0, 3'b011);
    send_poll(32'h0000_000E, 3'b011);
    send_poll(32'hFFFF_FFFF, 3'b111);
    wait_idle();

    // Zero debounce and zero long-press time.
    set_register(REG_DEBOUNCE, 16'd0);
    set_register(REG_LONG_PRESS, 16'd0);
    set_register(REG_UNUSED, 16'hFFFF);
    send_poll(32'd5000, 3'b110);
    send_poll(32'd5000, 3'b110);
    send_poll(32'd5001, 3'b111);
    send_poll(32'd5002, 3'b011);
    send_poll(32'd5003, 3'b011);
    cur_ms = 32'd5003;
    held_levels = 3'b011;

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin d = 0;     l = 0;     end
        1: begin d = 65535; l = 65535; end
        2: begin d = 1;     l = 0;     end
        3: begin d = 0;     l = 65535; end
        4: begin d = 65535; l = 0;     end
        5: begin d = 12;    l = 150;   end
        6: begin d = 30;    l = 1200;  end
        default: begin
          d = $urandom_range(0, 100);
          l = $urandom_range(0, 600);
        end
      endcase
      wait_idle();
      set_register(REG_DEBOUNCE, CFG_W'(d));
      if ($urandom_range(0, 2) == 0)
        set_register(REG_UNUSED, CFG_W'($urandom));
      set_register(REG_LONG_PRESS, CFG_W'(l));
      if ($urandom_range(0, 2) == 0)
        cur_ms = 32'hFFFF_FFFF - $urandom_range(0, 3 * (d + l) + 50);
      random_polls(d, l, 92);
    end

    wait_idle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
